/* rtl/sst_pkg.sv */
// shared codes, states and control bundles of the scoped symbol table
`default_nettype none
package sst_pkg;

  localparam int DEF_MAX_BINDINGS = 64;
  localparam int DEF_MAX_DEPTH    = 32;

  localparam int KEY_W   = 8;
  localparam int VALUE_W = 31;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_DEFINE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_OPEN   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLOSE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DEPTH = 2'd2;
  localparam logic [STAT_W-1:0] ST_ROOT  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_APPEND,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              rd;
    logic              dec_ptr;
    logic              cnt_from_ptr;
    logic              wr_over;
    logic              wr_app;
    logic              lvl_inc;
    logic              lvl_dec;
    logic              set_st;
    logic [STAT_W-1:0] st_code;
    logic              set_found;
    logic              push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic ptr_one;
    logic lvl_match;
    logic key_match;
    logic full;
    logic root;
    logic depth_max;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/sst_ctrl.sv */
// sequencer for define, lookup, open and close of the symbol table
`default_nettype none
module sst_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire [sst_pkg::OP_W-1:0] in_op,
  output logic                    in_ready,
  input  sst_pkg::stat_t          st,
  output sst_pkg::cmd_t           cmd
);
  import sst_pkg::*;

  state_t           state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_DEFINE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          unique case (in_op)
            OP_DEFINE: state_nxt = st.cnt_zero ? S_APPEND : S_RD;
            OP_LOOKUP: state_nxt = st.cnt_zero ? S_DONE : S_RD;
            OP_OPEN:   state_nxt = S_DONE;
            OP_CLOSE:  state_nxt = (st.root || st.cnt_zero) ? S_DONE : S_RD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        unique case (op_r)
          OP_DEFINE: begin
            if (!st.lvl_match)     state_nxt = S_APPEND;
            else if (st.key_match) state_nxt = S_DONE;
            else                   state_nxt = st.ptr_one ? S_APPEND : S_RD;
          end
          OP_LOOKUP: begin
            if (st.key_match) state_nxt = S_DONE;
            else              state_nxt = st.ptr_one ? S_DONE : S_RD;
          end
          default: begin
            if (st.lvl_match) state_nxt = st.ptr_one ? S_DONE : S_RD;
            else              state_nxt = S_DONE;
          end
        endcase
      end
      S_APPEND: state_nxt = S_DONE;
      S_DONE:   if (st.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.st_code = ST_OK;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_OPEN) begin
            if (st.depth_max) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_DEPTH;
            end else begin
              cmd.lvl_inc = 1'b1;
            end
          end else if (in_op == OP_CLOSE) begin
            if (st.root) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_ROOT;
            end else if (st.cnt_zero) begin
              cmd.lvl_dec = 1'b1;
            end
          end
        end
      end
      S_RD: cmd.rd = 1'b1;
      S_CMP: begin
        unique case (op_r)
          OP_DEFINE: begin
            if (st.lvl_match && st.key_match) cmd.wr_over = 1'b1;
            else if (st.lvl_match)            cmd.dec_ptr = 1'b1;
          end
          OP_LOOKUP: begin
            if (st.key_match) cmd.set_found = 1'b1;
            else              cmd.dec_ptr   = 1'b1;
          end
          default: begin
            if (st.lvl_match) begin
              cmd.dec_ptr      = 1'b1;
              cmd.cnt_from_ptr = 1'b1;
              cmd.lvl_dec      = st.ptr_one;
            end else begin
              cmd.lvl_dec = 1'b1;
            end
          end
        endcase
      end
      S_APPEND: begin
        if (st.full) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_FULL;
        end else begin
          cmd.wr_app = 1'b1;
        end
      end
      S_DONE:  cmd.push = st.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/sst_datapath.sv */
// binding memory, counters, compare logic and result register
`default_nettype none
module sst_datapath #(
  parameter int MAX_BINDINGS = sst_pkg::DEF_MAX_BINDINGS,
  parameter int MAX_DEPTH    = sst_pkg::DEF_MAX_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [sst_pkg::KEY_W-1:0]     in_key,
  input  wire [sst_pkg::VALUE_W-1:0]   in_value,
  input  sst_pkg::cmd_t                cmd,
  output sst_pkg::stat_t               st,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [sst_pkg::STAT_W-1:0]   out_status,
  output logic                         out_found,
  output logic [sst_pkg::VALUE_W-1:0]  out_value
);
  import sst_pkg::*;

  localparam int CNT_W = $clog2(MAX_BINDINGS + 1);
  localparam int IDX_W = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int ENT_W = LVL_W + KEY_W + VALUE_W;

  logic [ENT_W-1:0]   mem [MAX_BINDINGS];
  logic [ENT_W-1:0]   rdata_r;

  logic [CNT_W-1:0]   count_r, ptr_r;
  logic [LVL_W-1:0]   level_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [STAT_W-1:0]  res_status_r;
  logic               res_found_r;
  logic [VALUE_W-1:0] res_value_r;
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_found_r;
  logic [VALUE_W-1:0] out_value_r;

  logic [CNT_W-1:0]   ptr_m1;
  logic [IDX_W-1:0]   wr_addr;
  logic [LVL_W-1:0]   rd_level;
  logic [KEY_W-1:0]   rd_key;
  logic [VALUE_W-1:0] rd_value;

  assign ptr_m1  = ptr_r - CNT_W'(1);
  assign wr_addr = cmd.wr_app ? count_r[IDX_W-1:0] : ptr_m1[IDX_W-1:0];
  assign {rd_level, rd_key, rd_value} = rdata_r;

  // entry layout: level, key, value from the top bit down
  always_ff @(posedge clk) begin
    if (cmd.wr_over || cmd.wr_app) mem[wr_addr] <= {level_r, key_r, value_r};
    if (cmd.rd) rdata_r <= mem[ptr_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_app)       count_r <= count_r + CNT_W'(1);
      if (cmd.cnt_from_ptr) count_r <= ptr_m1;
      if (cmd.lvl_inc)      level_r <= level_r + LVL_W'(1);
      if (cmd.lvl_dec)      level_r <= level_r - LVL_W'(1);
      if (cmd.push)                  out_valid_r <= 1'b1;
      else if (out_ready)            out_valid_r <= 1'b0;
    end
  end

  // working registers of the current item, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ptr_r       <= count_r;
      key_r       <= in_key;
      value_r     <= in_value;
      res_found_r <= 1'b0;
      res_value_r <= '0;
    end
    if (cmd.dec_ptr) ptr_r <= ptr_m1;
    if (cmd.load || cmd.set_st) res_status_r <= cmd.set_st ? cmd.st_code : ST_OK;
    if (cmd.set_found) begin
      res_found_r <= 1'b1;
      res_value_r <= rd_value;
    end
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_value_r  <= res_value_r;
    end
  end

  always_comb begin
    st.cnt_zero  = (count_r == '0);
    st.ptr_one   = (ptr_r == CNT_W'(1));
    st.lvl_match = (rd_level == level_r);
    st.key_match = (rd_key == key_r);
    st.full      = (count_r == CNT_W'(MAX_BINDINGS));
    st.root      = (level_r == '0);
    st.depth_max = (level_r == LVL_W'(MAX_DEPTH));
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_value  = out_value_r;

endmodule
`default_nettype wire

/* rtl/scoped_symbol_table_core.sv */
// top level of the scoped symbol table: stream ports, controller and datapath
//
//  channel  dir  tdata (low bit up)                 tuser (low bit up)
//  in_      in   key[7:0], bind_value[38:8], zero    opcode[1:0]
//  out_     out  found_value[30:0], zero             status[1:0], found[2]
//
// open scope, a root close and a close of an empty store go from idle
// straight to done; lookup and close pass a read and a compare state per
// binding visited, define the same plus an append state when it appends, as
// the single read port of the binding memory is read once per step and
// compared in the next cycle (the longest walk: a new key in a full current scope)
// rst_n is synchronous and empties the store and returns to the root scope;
// the binding memory itself is not cleared
// one result register sits on the output; a new beat is taken while an
// earlier result still waits for out_tready
`default_nettype none
module scoped_symbol_table_core #(
  parameter int MAX_BINDINGS = sst_pkg::DEF_MAX_BINDINGS,
  parameter int MAX_DEPTH    = sst_pkg::DEF_MAX_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // key[7:0], bind_value[38:8], pad[39]
  input  wire  [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // found_value[30:0], pad[31]
  output logic [2:0]  out_tuser   // status[1:0], found[2]
);
  import sst_pkg::*;

  cmd_t               cmd;
  stat_t              st;
  logic [STAT_W-1:0]  res_status;
  logic               res_found;
  logic [VALUE_W-1:0] res_value;

  // sequencer: walks the binding stack newest first, one entry per step
  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // binding memory, count and scope level, result register
  sst_datapath #(
    .MAX_BINDINGS (MAX_BINDINGS),
    .MAX_DEPTH    (MAX_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_key     (in_tdata[KEY_W-1:0]),
    .in_value   (in_tdata[KEY_W+VALUE_W-1:KEY_W]),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_found  (res_found),
    .out_value  (res_value)
  );

  // pack result beat, pad bits tied low
  assign out_tdata = {1'b0, res_value};
  assign out_tuser = {res_found, res_status};

endmodule
`default_nettype wire
